// ===== rtl/flpt_pkg.sv =====
package flpt_pkg;

	// store geometry
	localparam int TABLE_PAGES = 16;
	localparam int SLOTS       = 512;
	localparam int SLOT_W      = 9;
	localparam int PAGE_W      = $clog2(TABLE_PAGES);
	localparam int STORE_DEPTH = TABLE_PAGES * SLOTS;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);
	localparam int NFP_W       = ($clog2(TABLE_PAGES + 1) > 5) ? $clog2(TABLE_PAGES + 1) : 5;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] CFG_ROOT      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLAGS     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NO_EXEC   = 2'd3;

	// request types
	localparam logic [1:0] REQ_MAP    = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_RAW    = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_INVALID   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_NO_PAGES  = 2'd3;

	// leaf sizes
	localparam logic [1:0] SZ_4K = 2'd0;
	localparam logic [1:0] SZ_2M = 2'd1;
	localparam logic [1:0] SZ_1G = 2'd2;

	// walk levels
	localparam logic [1:0] LVL_PML4 = 2'd0;
	localparam logic [1:0] LVL_PDPT = 2'd1;
	localparam logic [1:0] LVL_PD   = 2'd2;
	localparam logic [1:0] LVL_PT   = 2'd3;

	typedef struct packed {
		logic       load;
		logic       rd;
		logic       descend;
		logic       alloc;
		logic       zero;
		logic       link;
		logic       wr_leaf;
		logic       wr_raw;
		logic       sweep;
		logic       res_load;
		logic [1:0] res_status;
		logic [1:0] res_size;
		logic       res_pa;
	} flpt_cmd_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic       misaligned;
		logic       raw_ok;
		logic       ent_p;
		logic       ent_ps;
		logic [1:0] level;
		logic       no_pages;
		logic       zero_last;
		logic       sweep_last;
		logic       res_free;
	} flpt_sts_t;

endpackage

// ===== rtl/flpt_req_if.sv =====
interface flpt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [47:0] virt_addr;
	logic [51:0] phys_target;
	logic [12:0] entry_index;
	logic [63:0] entry_value;

	modport source (output valid, req_type, virt_addr, phys_target, entry_index, entry_value,
		input ready);
	modport sink (input valid, req_type, virt_addr, phys_target, entry_index, entry_value,
		output ready);
endinterface

// ===== rtl/flpt_rsp_if.sv =====
interface flpt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [51:0] phys_addr;
	logic [1:0]  leaf_size;

	modport source (output valid, status, phys_addr, leaf_size, input ready);
	modport sink (input valid, status, phys_addr, leaf_size, output ready);
endinterface

// ===== rtl/flpt_ram.sv =====
module flpt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/flpt_dp.sv =====
module flpt_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  flpt_pkg::flpt_cmd_t           cmd,
	output flpt_pkg::flpt_sts_t           sts,
	input  logic [1:0]                    req_type,
	input  logic [47:0]                   virt_addr,
	input  logic [51:0]                   phys_target,
	input  logic [12:0]                   entry_index,
	input  logic [63:0]                   entry_value,
	input  logic                          cfg_we,
	input  logic [flpt_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [flpt_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    out_status,
	output logic [51:0]                   out_phys_addr,
	output logic [1:0]                    out_leaf_size
);
	import flpt_pkg::*;

	logic [1:0]          type_q;
	logic [47:0]         va_q;
	logic [51:0]         pa_q;
	logic [12:0]         idx_q;
	logic [63:0]         val_q;
	logic [1:0]          level_q;
	logic [PAGE_W-1:0]   page_q;
	logic [PAGE_W-1:0]   np_q;
	logic [STORE_AW-1:0] addr_q;
	logic [STORE_AW-1:0] cnt_q;
	logic [NFP_W-1:0]    nfp_q;
	logic [3:0]          root_q;
	logic [11:0]         flags_q;
	logic                nx_q;
	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [51:0]         phys_q;
	logic [1:0]          size_q;

	logic [SLOT_W-1:0]   slot;
	logic [STORE_AW-1:0] rd_addr;
	logic                mem_we;
	logic [STORE_AW-1:0] mem_waddr;
	logic [63:0]         mem_wdata;
	logic [63:0]         rd_data;
	logic [51:0]         walk_pa;

	// slot of the current level
	always_comb begin
		case (level_q)
			LVL_PML4: slot = va_q[47:39];
			LVL_PDPT: slot = va_q[38:30];
			LVL_PD:   slot = va_q[29:21];
			default:  slot = va_q[20:12];
		endcase
	end

	assign rd_addr = {page_q, slot};

	// store write select, one source per cycle
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = '0;
		if (cmd.sweep) begin
			mem_we = 1'b1;
		end else if (cmd.zero) begin
			mem_we    = 1'b1;
			mem_waddr = {np_q, cnt_q[SLOT_W-1:0]};
		end else if (cmd.link) begin
			mem_we    = 1'b1;
			mem_waddr = addr_q;
			mem_wdata = {12'd0, 40'(np_q), 12'h003};
		end else if (cmd.wr_leaf) begin
			mem_we    = 1'b1;
			mem_waddr = addr_q;
			mem_wdata = {nx_q, 11'd0, pa_q[51:12], flags_q};
		end else if (cmd.wr_raw) begin
			mem_we    = 1'b1;
			mem_waddr = STORE_AW'(idx_q);
			mem_wdata = val_q;
		end
	end

	flpt_ram #(
		.WIDTH(64),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (cmd.rd),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// translated address by leaf size
	always_comb begin
		case (cmd.res_size)
			SZ_1G:   walk_pa = {rd_data[51:30], va_q[29:0]};
			SZ_2M:   walk_pa = {rd_data[51:21], va_q[20:0]};
			default: walk_pa = {rd_data[51:12], va_q[11:0]};
		endcase
	end

	// request word, read address, allocated page and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q <= req_type;
			va_q   <= virt_addr;
			pa_q   <= phys_target;
			idx_q  <= entry_index;
			val_q  <= entry_value;
		end
		if (cmd.rd) begin
			addr_q <= rd_addr;
		end
		if (cmd.alloc) begin
			np_q <= PAGE_W'(nfp_q);
		end
		if (cmd.res_load) begin
			status_q <= cmd.res_status;
			size_q   <= cmd.res_size;
			phys_q   <= cmd.res_pa ? walk_pa : '0;
		end
	end

	// walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LVL_PML4;
			page_q  <= '0;
		end else if (cmd.load) begin
			level_q <= LVL_PML4;
			page_q  <= PAGE_W'(root_q);
		end else if (cmd.descend) begin
			level_q <= level_q + 2'd1;
			page_q  <= rd_data[12 +: PAGE_W];
		end else if (cmd.link) begin
			level_q <= level_q + 2'd1;
			page_q  <= np_q;
		end
	end

	// sweep counter for clearing and zeroing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.alloc) begin
			cnt_q <= '0;
		end else if (cmd.sweep || cmd.zero) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// configuration and allocator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q  <= '0;
			nfp_q   <= NFP_W'(1);
			flags_q <= 12'd3;
			nx_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ROOT:    root_q  <= cfg_data[3:0];
				CFG_FIRST:   nfp_q   <= NFP_W'(cfg_data[4:0]);
				CFG_FLAGS:   flags_q <= cfg_data[11:0];
				CFG_NO_EXEC: nx_q    <= cfg_data[0];
				default:     ;
			endcase
		end else if (cmd.alloc) begin
			nfp_q <= nfp_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_status    = status_q;
	assign out_phys_addr = phys_q;
	assign out_leaf_size = size_q;

	// status toward the controller
	always_comb begin
		sts.req_type   = type_q;
		sts.misaligned = (va_q[11:0] != 12'd0) || (pa_q[11:0] != 12'd0);
		sts.raw_ok     = 32'(idx_q) < 32'(STORE_DEPTH);
		sts.ent_p      = rd_data[0];
		sts.ent_ps     = rd_data[7];
		sts.level      = level_q;
		sts.no_pages   = 32'(nfp_q) >= 32'(TABLE_PAGES);
		sts.zero_last  = cnt_q[SLOT_W-1:0] == {SLOT_W{1'b1}};
		sts.sweep_last = cnt_q == {STORE_AW{1'b1}};
		sts.res_free   = !out_valid_q || out_ready;
	end

endmodule

// ===== rtl/flpt_ctrl.sv =====
module flpt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  flpt_pkg::flpt_sts_t sts,
	output flpt_pkg::flpt_cmd_t cmd
);
	import flpt_pkg::*;

	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_DISP = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_EVAL = 3'd4;
	localparam logic [2:0] S_ZERO = 3'd5;
	localparam logic [2:0] S_LINK = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0] state_q, state_d;
	logic [1:0] st_q, st_d;
	logic [1:0] sz_q, sz_d;
	logic       pa_q, pa_d;

	assign in_ready = state_q == S_IDLE;

	// next state and commands
	always_comb begin
		state_d = state_q;
		st_d    = st_q;
		sz_d    = sz_q;
		pa_d    = pa_q;
		cmd     = '0;
		case (state_q)
			S_CLR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				st_d    = ST_INVALID;
				sz_d    = SZ_4K;
				pa_d    = 1'b0;
				state_d = S_DONE;
				case (sts.req_type)
					REQ_MAP: begin
						if (!sts.misaligned) begin
							state_d = S_RD;
						end
					end
					REQ_LOOKUP: state_d = S_RD;
					REQ_RAW: begin
						if (sts.raw_ok) begin
							cmd.wr_raw = 1'b1;
							st_d       = ST_OK;
						end
					end
					default: ;
				endcase
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_EVAL;
			end
			S_EVAL: begin
				state_d = S_DONE;
				if (sts.req_type == REQ_MAP) begin
					if (sts.level == LVL_PT) begin
						if (sts.ent_p) begin
							st_d = ST_INVALID;
						end else begin
							cmd.wr_leaf = 1'b1;
							st_d        = ST_OK;
						end
					end else if (sts.ent_p) begin
						if (sts.ent_ps) begin
							st_d = ST_INVALID;
						end else begin
							cmd.descend = 1'b1;
							state_d     = S_RD;
						end
					end else if (sts.no_pages) begin
						st_d = ST_NO_PAGES;
					end else begin
						cmd.alloc = 1'b1;
						state_d   = S_ZERO;
					end
				end else begin
					// lookup: top-level size bit reads as a pointer
					if (!sts.ent_p) begin
						st_d = ST_NOT_FOUND;
					end else if (sts.ent_ps && sts.level == LVL_PDPT) begin
						st_d = ST_OK;
						sz_d = SZ_1G;
						pa_d = 1'b1;
					end else if (sts.ent_ps && sts.level == LVL_PD) begin
						st_d = ST_OK;
						sz_d = SZ_2M;
						pa_d = 1'b1;
					end else if (sts.level == LVL_PT) begin
						st_d = ST_OK;
						sz_d = SZ_4K;
						pa_d = 1'b1;
					end else begin
						cmd.descend = 1'b1;
						state_d     = S_RD;
					end
				end
			end
			S_ZERO: begin
				cmd.zero = 1'b1;
				if (sts.zero_last) begin
					state_d = S_LINK;
				end
			end
			S_LINK: begin
				cmd.link = 1'b1;
				state_d  = S_RD;
			end
			S_DONE: begin
				if (sts.res_free) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = st_q;
					cmd.res_size   = sz_q;
					cmd.res_pa     = pa_q;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			st_q    <= ST_OK;
			sz_q    <= SZ_4K;
			pa_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			sz_q    <= sz_d;
			pa_q    <= pa_d;
		end
	end

endmodule

// ===== rtl/four_level_page_table_map_lookup_top.sv =====
// Four-level page-table store with map, lookup and raw entry write requests.
// req channel: one word per request (req_type, virt_addr, phys_target,
// entry_index, entry_value), taken when valid and ready are both high.
// rsp channel: one word per request (status, phys_addr, leaf_size), in order.
// cfg port: cfg_we writes cfg_data into register cfg_idx (root page, first
// free page, leaf flags, leaf no-execute); write only while the block is idle.
// After reset the store is cleared one word a cycle, all 8192 words, with ready low.
// Each table level is walked as a store read (S_RD) then an evaluation (S_EVAL);
// a raw write or rejected request goes from dispatch straight to S_DONE, and
// every table page the map allocates is zeroed (S_ZERO) then linked (S_LINK).
// One request is worked at a time; a new request is taken while the last
// response still waits in the output register. If the receiver stalls, the
// next response holds in the controller until the output register frees.
module four_level_page_table_map_lookup_top (
	input  logic                            clk,
	input  logic                            arst_n,
	flpt_req_if.sink                        req,
	flpt_rsp_if.source                      rsp,
	input  logic                            cfg_we,
	input  logic [flpt_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [flpt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import flpt_pkg::*;

	flpt_cmd_t cmd;
	flpt_sts_t sts;
	logic      in_ready;

	assign req.ready = in_ready;

	// walk sequencer
	flpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// store, walk registers and output register
	flpt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req.req_type),
		.virt_addr     (req.virt_addr),
		.phys_target   (req.phys_target),
		.entry_index   (req.entry_index),
		.entry_value   (req.entry_value),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.out_valid     (rsp.valid),
		.out_ready     (rsp.ready),
		.out_status    (rsp.status),
		.out_phys_addr (rsp.phys_addr),
		.out_leaf_size (rsp.leaf_size)
	);

`ifndef NO_ASSERTIONS
	// a response is loaded only into a free output register
	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> sts.res_free)
		else $error("response loaded over a pending one");

	// at most one store write source per cycle
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.sweep, cmd.zero, cmd.link, cmd.wr_leaf, cmd.wr_raw}))
		else $error("store write conflict");

	// an accepted request makes the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while busy");
`endif

endmodule
